>>> sv/qwlt_pkg.sv
// Shared types and constants for the quoted word line tokenizer.
// No dependencies; every other file imports this package.
package qwlt_pkg;

  // request codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TOKEND  = 2'd1;
  localparam logic [1:0] KIND_LINEEND = 2'd2;

  // characters the scanner reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

  // most results one item can cause
  localparam int unsigned MAX_RES = 3;

  // scanner mode, one-hot
  typedef enum logic [4:0] {
    MODE_SKIP = 5'b00001,
    MODE_WORD = 5'b00010,
    MODE_QUOT = 5'b00100,
    MODE_CMNT = 5'b01000,
    MODE_SLSH = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic       last;
  } out_item_t;

  // one result without its position flag
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
  } res_t;

  // all results of one item
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    scan_mode_t mode;
    logic [7:0] quote_mark;
    logic       token_open;
    logic       line_had_token;
  } scan_state_t;

endpackage

>>> sv/qwlt_step.sv
// Scanner step: from the current state and one item, the next state and the
// list of results that item causes. Depends on qwlt_pkg.
module qwlt_step import qwlt_pkg::*; (
  input  in_item_t    item,
  input  scan_state_t cur,
  output scan_state_t nxt,
  output bundle_t     bundle
);

  logic       is_eol;
  logic       is_space;
  logic       is_quote;
  logic       b1_v;
  logic [7:0] b1_c;
  logic       b2_v;
  logic [7:0] b2_c;
  logic       te;
  logic       le;
  logic [1:0] n;
  logic [7:0] c;

  assign c        = item.text_byte;
  assign is_eol   = (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
  assign is_space = (c == CH_SPACE) || (c == CH_TAB);
  assign is_quote = (c == CH_DQUOTE) || (c == CH_BQUOTE) || (c == CH_SQUOTE);

  // mode update and result flags
  always_comb begin
    b1_v = 1'b0;
    b1_c = '0;
    b2_v = 1'b0;
    b2_c = '0;
    te   = 1'b0;
    le   = 1'b0;
    nxt  = cur;
    if (item.req_type == REQ_FLUSH) begin
      // pending slash becomes a one-byte word, then token and line close
      if (cur.mode == MODE_SLSH) begin
        b1_v = 1'b1;
        b1_c = CH_SLASH;
      end
      te = cur.token_open || (cur.mode == MODE_SLSH);
      le = cur.line_had_token || (cur.mode == MODE_SLSH);
      nxt.mode           = MODE_SKIP;
      nxt.token_open     = 1'b0;
      nxt.line_had_token = 1'b0;
    end else begin
      unique case (cur.mode)
        MODE_WORD: begin
          if (is_eol) begin
            te = cur.token_open;
            le = cur.line_had_token;
            nxt.mode           = MODE_SKIP;
            nxt.token_open     = 1'b0;
            nxt.line_had_token = 1'b0;
          end else if (is_space) begin
            te = cur.token_open;
            nxt.mode       = MODE_SKIP;
            nxt.token_open = 1'b0;
          end else begin
            b1_v = 1'b1;
            b1_c = c;
            nxt.token_open     = 1'b1;
            nxt.line_had_token = 1'b1;
          end
        end
        MODE_QUOT: begin
          if (c == cur.quote_mark) begin
            te = cur.token_open;
            nxt.mode       = MODE_SKIP;
            nxt.token_open = 1'b0;
          end else if (is_eol) begin
            te = cur.token_open;
            le = cur.line_had_token;
            nxt.mode           = MODE_SKIP;
            nxt.token_open     = 1'b0;
            nxt.line_had_token = 1'b0;
          end else begin
            b1_v = 1'b1;
            b1_c = c;
            nxt.token_open     = 1'b1;
            nxt.line_had_token = 1'b1;
          end
        end
        MODE_CMNT: begin
          if (is_eol) begin
            te = cur.token_open;
            le = cur.line_had_token;
            nxt.mode           = MODE_SKIP;
            nxt.token_open     = 1'b0;
            nxt.line_had_token = 1'b0;
          end
        end
        MODE_SLSH: begin
          if (c == CH_SLASH) begin
            nxt.mode = MODE_CMNT;
          end else begin
            // the slash opens a word, this byte is handled inside it
            b1_v = 1'b1;
            b1_c = CH_SLASH;
            nxt.token_open     = 1'b1;
            nxt.line_had_token = 1'b1;
            nxt.mode           = MODE_WORD;
            if (is_eol) begin
              te = 1'b1;
              le = 1'b1;
              nxt.mode           = MODE_SKIP;
              nxt.token_open     = 1'b0;
              nxt.line_had_token = 1'b0;
            end else if (is_space) begin
              te = 1'b1;
              nxt.mode       = MODE_SKIP;
              nxt.token_open = 1'b0;
            end else begin
              b2_v = 1'b1;
              b2_c = c;
            end
          end
        end
        default: begin
          // skip mode: whitespace is skipped; other bytes end the line or open a comment, slash, quote or word
          if (is_space) begin
            nxt.mode = cur.mode;
          end else if (is_eol) begin
            te = cur.token_open;
            le = cur.line_had_token;
            nxt.mode           = MODE_SKIP;
            nxt.token_open     = 1'b0;
            nxt.line_had_token = 1'b0;
          end else if (c == CH_HASH) begin
            nxt.mode = MODE_CMNT;
          end else if (c == CH_SLASH) begin
            nxt.mode = MODE_SLSH;
          end else if (is_quote) begin
            nxt.quote_mark = c;
            nxt.token_open = 1'b0;
            nxt.mode       = MODE_QUOT;
          end else begin
            b1_v = 1'b1;
            b1_c = c;
            nxt.mode           = MODE_WORD;
            nxt.token_open     = 1'b1;
            nxt.line_had_token = 1'b1;
          end
        end
      endcase
    end
  end

  // pack the flagged results in output order
  always_comb begin
    bundle = '0;
    n      = '0;
    if (b1_v) begin
      bundle.res[n] = '{kind: KIND_BYTE, token_byte: b1_c};
      n = n + 2'd1;
    end
    if (b2_v) begin
      bundle.res[n] = '{kind: KIND_BYTE, token_byte: b2_c};
      n = n + 2'd1;
    end
    if (te) begin
      bundle.res[n] = '{kind: KIND_TOKEND, token_byte: 8'h00};
      n = n + 2'd1;
    end
    if (le && (n != 2'd3)) begin
      bundle.res[n] = '{kind: KIND_LINEEND, token_byte: 8'h00};
      n = n + 2'd1;
    end
    bundle.cnt = n;
  end

endmodule

>>> sv/qwlt_serial.sv
// Result register: holds the results of one item and hands them out one per
// cycle on the output channel while out_ready is high. Depends on qwlt_pkg.
module qwlt_serial import qwlt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  bundle_t   bundle,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  res_t [MAX_RES-1:0] res_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic [1:0]         idx_r;
  logic [1:0]         idx_nxt;
  logic               final_res;
  logic               take;
  res_t               cur_res;

  assign out_valid = (cnt_r != 2'd0);
  assign final_res = (idx_r == (cnt_r - 2'd1));
  assign take      = out_valid && out_ready;
  assign can_load  = !out_valid || (take && final_res);

  // current result
  always_comb begin
    unique case (idx_r)
      2'd1:    cur_res = res_r[1];
      2'd2:    cur_res = res_r[2];
      default: cur_res = res_r[0];
    endcase
  end

  assign out_data = '{kind: cur_res.kind, token_byte: cur_res.token_byte,
                      last: final_res};

  // count and position
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (take) begin
      if (final_res) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load) begin
      cnt_nxt = bundle.cnt;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end
  end

endmodule

>>> sv/quoted_word_line_tokenizer.sv
// Top level of the quoted word line tokenizer: input register, scanner state
// and result register. Depends on qwlt_pkg, qwlt_step and qwlt_serial.

// Splits a byte stream into tokens and lines. Each input item is one text
// byte or an end-of-text flush; each result item is a token byte, an
// end-of-token or an end-of-line marker, with last set on the final result
// of its input item. Space and tab separate words; double quote, backquote
// and single quote open a token running to the same mark or the line end;
// outside a token, a hash or two slashes open a comment to the line end;
// NUL, CR and LF end a line. An item is held in an input register and
// scanned combinationally; its results go to a result register that hands
// out one result per cycle while out_ready is high, and an item causes at
// most three results. Items with no result stream at one per cycle, as do
// one-result items while out_ready is high; else the serializer sets the rate.
module quoted_word_line_tokenizer import qwlt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic        in_vld_r;
  in_item_t    in_item_r;
  scan_state_t state_r;
  scan_state_t state_nxt;
  bundle_t     bundle;
  logic        can_load;
  logic        advance;
  logic        load;

  // scan step
  qwlt_step u_step (
    .item   (in_item_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .bundle (bundle)
  );

  // an item with no results moves on even while the output is busy
  assign advance  = in_vld_r && ((bundle.cnt == 2'd0) || can_load);
  assign load     = advance && (bundle.cnt != 2'd0);
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_SKIP, quote_mark: 8'h00, token_open: 1'b0,
                   line_had_token: 1'b0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register and output
  qwlt_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/quoted_word_line_tokenizer_tb.sv
// Self-checking testbench for quoted_word_line_tokenizer: directed table, then random lines.
// Results are predicted in-bench and compared item by item.
// Depends on qwlt_pkg and the quoted_word_line_tokenizer RTL.
`timescale 1ns / 100ps

module quoted_word_line_tokenizer_tb;
  import qwlt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_ITEMS = 260;
  localparam int DRAIN_CYCLES = 20;

  // classes of random characters
  localparam int CL_START  = 0;
  localparam int CL_WORD   = 1;
  localparam int CL_QUOTED = 2;
  localparam int CL_NOTEOL = 3;

  // one row of stimulus; typed rows carry their own expected results
  typedef struct packed {
    in_item_t           item;
    logic               typed;
    logic [1:0]         cnt;
    out_item_t [2:0]    res;
  } text_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  quoted_word_line_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // scanner state mirror and results of the current item
  scan_state_t scan;
  out_item_t   step_res [MAX_RES];
  int          step_cnt;

  out_item_t   tok_q [$];
  text_row_t   line_q [$];
  text_row_t   dir_rows [$];
  out_item_t   want;
  int          errors;
  int          sent_items;
  int          cycles;
  bit          calm;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // queue helpers
  function automatic void queue_tok(out_item_t t);
    tok_q.insert(tok_q.size(), t);
  endfunction

  function automatic void queue_line(text_row_t r);
    line_q.insert(line_q.size(), r);
  endfunction

  function automatic void queue_dir(text_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic bit is_eol(logic [7:0] c);
    return c == CH_NUL || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_quote(logic [7:0] c);
    return c == CH_DQUOTE || c == CH_BQUOTE || c == CH_SQUOTE;
  endfunction

  // token stream prediction
  function automatic void push_res(logic [1:0] kind, logic [7:0] ch);
    if (step_cnt < MAX_RES) begin
      step_res[step_cnt] = {kind, (kind == KIND_BYTE) ? ch : 8'h00, 1'b0};
      step_cnt++;
    end
  endfunction

  function automatic void put_byte(logic [7:0] ch);
    push_res(KIND_BYTE, ch);
    scan.token_open = 1'b1;
    scan.line_had_token = 1'b1;
  endfunction

  function automatic void close_token();
    if (scan.token_open) push_res(KIND_TOKEND, 8'h00);
    scan.token_open = 1'b0;
  endfunction

  function automatic void close_line();
    close_token();
    if (scan.line_had_token) push_res(KIND_LINEEND, 8'h00);
    scan.line_had_token = 1'b0;
    scan.mode = MODE_SKIP;
  endfunction

  function automatic void word_byte(logic [7:0] c);
    if (is_eol(c)) begin
      close_line();
    end else if (is_blank(c)) begin
      close_token();
      scan.mode = MODE_SKIP;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic void tokenize_item(in_item_t it);
    logic [7:0] c;
    c = it.text_byte;
    step_cnt = 0;
    if (it.req_type == REQ_FLUSH) begin
      // end of text: a pending slash is a one-byte word
      if (scan.mode == MODE_SLSH) put_byte(CH_SLASH);
      close_line();
    end else begin
      case (scan.mode)
        MODE_WORD: word_byte(c);
        MODE_QUOT: begin
          if (c == scan.quote_mark) begin
            close_token();
            scan.mode = MODE_SKIP;
          end else if (is_eol(c)) begin
            close_line();
          end else begin
            put_byte(c);
          end
        end
        MODE_CMNT: begin
          if (is_eol(c)) close_line();
        end
        MODE_SLSH: begin
          if (c == CH_SLASH) begin
            scan.mode = MODE_CMNT;
          end else begin
            put_byte(CH_SLASH);
            scan.mode = MODE_WORD;
            word_byte(c);
          end
        end
        default: begin
          if (is_blank(c)) begin
          end else if (is_eol(c)) begin
            close_line();
          end else if (c == CH_HASH) begin
            scan.mode = MODE_CMNT;
          end else if (c == CH_SLASH) begin
            scan.mode = MODE_SLSH;
          end else if (is_quote(c)) begin
            scan.quote_mark = c;
            scan.token_open = 1'b0;
            scan.mode = MODE_QUOT;
          end else begin
            scan.mode = MODE_WORD;
            put_byte(c);
          end
        end
      endcase
    end
    if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
  endfunction

  function automatic text_row_t text_row(logic req, logic [7:0] ch, logic typed = 1'b0,
                                         logic [1:0] cnt = 2'd0, out_item_t r0 = '0,
                                         out_item_t r1 = '0, out_item_t r2 = '0);
    text_row_t r;
    r.item.req_type = req;
    r.item.text_byte = ch;
    r.typed = typed;
    r.cnt = cnt;
    r.res[0] = r0;
    r.res[1] = r1;
    r.res[2] = r2;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_char(int cls, logic [7:0] q);
    logic [7:0] c;
    bit bad;
    do begin
      c = 8'($urandom_range(0, 255));
      case (cls)
        CL_START:  bad = is_blank(c) || is_eol(c) || is_quote(c) || c == CH_HASH ||
                         c == CH_SLASH;
        CL_WORD:   bad = is_blank(c) || is_eol(c);
        CL_QUOTED: bad = is_eol(c) || c == q;
        default:   bad = is_eol(c);
      endcase
    end while (bad);
    return c;
  endfunction

  function automatic void add_byte(logic [7:0] c);
    queue_line(text_row(REQ_BYTE, c));
  endfunction

  // one well-formed line with random content, plus some noise
  function automatic void build_line();
    int pieces;
    int len;
    logic [7:0] q;
    pieces = $urandom_range(1, 5);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          add_byte(rand_char(CL_START, 8'h00));
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) add_byte(rand_char(CL_WORD, 8'h00));
        end
        4: begin
          case ($urandom_range(0, 2))
            0:       q = CH_DQUOTE;
            1:       q = CH_BQUOTE;
            default: q = CH_SQUOTE;
          endcase
          add_byte(q);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) add_byte(rand_char(CL_QUOTED, q));
          if ($urandom_range(0, 4) != 0) add_byte(q);
        end
        5: begin
          if ($urandom_range(0, 1) != 0) begin
            add_byte(CH_HASH);
          end else begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
          end
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++) add_byte(rand_char(CL_NOTEOL, 8'h00));
        end
        6: begin
          add_byte(CH_SLASH);
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) add_byte(rand_char(CL_WORD, 8'h00));
        end
        7: add_byte(8'($urandom_range(0, 255)));
        8: add_byte(CH_SLASH);
        default: begin
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
      endcase
      if ($urandom_range(0, 9) < 7) add_byte($urandom_range(0, 2) ? CH_SPACE : CH_TAB);
    end
    // line end, a flush, or a run-on into the next line
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: add_byte(CH_CR);
      6, 7, 8, 9, 10:   add_byte(CH_LF);
      11, 12, 13:       add_byte(CH_NUL);
      14, 15, 16: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
      17, 18: queue_line(text_row(REQ_FLUSH, 8'($urandom_range(0, 255))));
      default: ;
    endcase
  endfunction

  // drive one item, predict its results at acceptance
  task automatic send_row(text_row_t r);
    int g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r.item;
    do @(posedge clk); while (!in_ready);
    tokenize_item(r.item);
    if (r.typed) begin
      for (int i = 0; i < r.cnt; i++) queue_tok(r.res[i]);
    end else begin
      for (int i = 0; i < step_cnt; i++) queue_tok(step_res[i]);
    end
    sent_items++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tok_q.size() == 0) begin
        $error("unexpected result: kind %0d token_byte %02h last %0b",
               out_data.kind, out_data.token_byte, out_data.last);
        errors++;
      end else begin
        want = tok_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          errors++;
        end
        if (out_data.token_byte !== want.token_byte) begin
          $error("token_byte: expected %02h, got %02h", want.token_byte, out_data.token_byte);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quoted_word_line_tokenizer_tb NOT OK");
      $finish;
    end
  end

  // receiver stalls, with calm stretches
  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 4);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = gap_len();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    errors     = 0;
    cycles     = 0;
    sent_items = 0;
    calm       = 1'b0;
    scan.mode           = MODE_SKIP;
    scan.quote_mark     = 8'h00;
    scan.token_open     = 1'b0;
    scan.line_had_token = 1'b0;

    // directed rows: extremes, quoting, comments, slashes, line ends
    queue_dir(text_row(REQ_FLUSH, 8'hff, 1'b1, 2'd0));
    queue_dir(text_row(REQ_BYTE, 8'hff, 1'b1, 2'd1, {KIND_BYTE, 8'hff, 1'b1}));
    queue_dir(text_row(REQ_BYTE, CH_DQUOTE));
    queue_dir(text_row(REQ_BYTE, CH_TAB, 1'b1, 2'd1, {KIND_TOKEND, 8'h00, 1'b1}));
    queue_dir(text_row(REQ_BYTE, CH_DQUOTE, 1'b1, 2'd0));
    queue_dir(text_row(REQ_BYTE, CH_DQUOTE, 1'b1, 2'd0));
    queue_dir(text_row(REQ_BYTE, CH_BQUOTE));
    queue_dir(text_row(REQ_BYTE, CH_SPACE));
    queue_dir(text_row(REQ_BYTE, CH_BQUOTE));
    queue_dir(text_row(REQ_BYTE, "x"));
    queue_dir(text_row(REQ_BYTE, CH_CR, 1'b1, 2'd2, {KIND_TOKEND, 8'h00, 1'b0},
                       {KIND_LINEEND, 8'h00, 1'b1}));
    queue_dir(text_row(REQ_BYTE, CH_LF, 1'b1, 2'd0));
    queue_dir(text_row(REQ_BYTE, CH_HASH));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_BYTE, CH_LF, 1'b1, 2'd0));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_BYTE, "a"));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_BYTE, CH_SPACE));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_BYTE, CH_NUL, 1'b1, 2'd1, {KIND_LINEEND, 8'h00, 1'b1}));
    queue_dir(text_row(REQ_BYTE, CH_SQUOTE));
    queue_dir(text_row(REQ_BYTE, "z"));
    queue_dir(text_row(REQ_BYTE, CH_SLASH));
    queue_dir(text_row(REQ_FLUSH, 8'h00, 1'b1, 2'd2, {KIND_TOKEND, 8'h00, 1'b0},
                       {KIND_LINEEND, 8'h00, 1'b1}));

    // reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // random lines until enough items are sent
    while (sent_items < TOTAL_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      build_line();
      while (line_q.size() != 0) send_row(line_q.pop_front());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain
    while (tok_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("quoted_word_line_tokenizer_tb OK");
    end else begin
      $display("quoted_word_line_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
